FILE: design/b64d_pkg.sv
// Shared types, codes and the alphabet lookup of the base64 line decoder.
package b64d_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int MAX_RESULTS = 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Result status codes.
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Line parser phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PLUS = 3'd1;
  localparam logic [2:0] PH_E1   = 3'd2;
  localparam logic [2:0] PH_E2   = 3'd3;
  localparam logic [2:0] PH_E3   = 3'd4;
  localparam logic [2:0] PH_E4   = 3'd5;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [5:0] SEXTET_PLUS = 6'd62;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    count_t     count;
  } result_t;

  // Alphabet lookup: bit 6 set means the character is outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CH_PLUS) begin
      s = {1'b0, SEXTET_PLUS};
    end else if (c == CH_SLASH) begin
      s = 7'd63;
    end
    return s;
  endfunction

endpackage

FILE: design/b64d_char_if.sv
// Valid/ready channel that carries one text character per beat.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       line_start;

  modport source (output valid, output in_char, output line_start, input ready);
  modport sink (input valid, input in_char, input line_start, output ready);
endinterface

FILE: design/b64d_result_if.sv
// Valid/ready channel that carries one decoder result per beat.
interface b64d_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output out_byte, output status, output byte_count,
                  output last, input ready);
  modport sink (input valid, input out_byte, input status, input byte_count,
                input last, output ready);
endinterface

FILE: design/base64_decoder.sv
// Streaming base64 line decoder: one character in, up to three results out.
// The first result of a character is registered and on the output in the cycle after its beat.
// One character is taken per cycle while each yields at most one result and the output
// is ready; a character that closes a group yields up to three results, which leave the
// single output port one per cycle while ready, and the next character waits for the last.
// Reset (synchronous, active high) returns the parser to idle and empties the result buffer.
module base64_decoder import b64d_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  b64d_char_if.sink     chars,
  b64d_result_if.source results
);

  // Parser state, updated only when a character beat is taken.
  logic [2:0] phase;
  logic [5:0] sextet_one;
  logic [5:0] sextet_two;
  logic [5:0] sextet_three;
  logic       third_is_pad;
  count_t     decoded_count;

  // Result buffer: holds every result of the last taken character.
  result_t    entries [MAX_RESULTS];
  logic       buf_valid;
  logic [1:0] rd_idx;
  logic [1:0] last_idx;

  logic [2:0] phase_next;
  logic [5:0] sextet_one_next;
  logic [5:0] sextet_two_next;
  logic [5:0] sextet_three_next;
  logic       third_is_pad_next;
  count_t     count_next;
  result_t    res [MAX_RESULTS];
  logic [2:0] n_res;

  logic       take;
  logic       pop;
  logic       pop_last;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  assign pop      = results.valid && results.ready;
  assign pop_last = pop && (rd_idx == last_idx);
  // A new character is taken when the buffer is empty or drains its final beat now.
  assign chars.ready = !buf_valid || (results.ready && rd_idx == last_idx);
  assign take     = chars.valid && chars.ready;

  // Whole decision for one character. Results are appended to res in order, and the
  // running count advances with each data byte so each result carries its own count.
  always_comb begin
    logic [6:0] s;
    logic [7:0] c;
    logic       invalid;
    logic       is_pad;
    logic       first_due;
    logic       second_due;
    logic [5:0] s_one;

    c       = chars.in_char;
    s       = sextet_of(c);
    invalid = s[6];
    is_pad  = (c == CH_PAD);
    first_due  = 1'b0;
    second_due = 1'b0;
    s_one      = sextet_one;

    phase_next        = phase;
    sextet_one_next   = sextet_one;
    sextet_two_next   = sextet_two;
    sextet_three_next = sextet_three;
    third_is_pad_next = third_is_pad;
    count_next        = decoded_count;
    n_res             = 3'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    if (chars.line_start) begin
      // A new line abandons whatever was in progress.
      count_next        = '0;
      third_is_pad_next = 1'b0;
      if (c == CH_PLUS) begin
        phase_next = PH_PLUS;
      end else begin
        first_due = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_PLUS: begin
          if (c == CH_SPACE) begin
            phase_next = PH_E1;
          end else begin
            // A lone leading '+' is the alphabet character opening the group.
            s_one           = SEXTET_PLUS;
            sextet_one_next = SEXTET_PLUS;
            second_due      = 1'b1;
          end
        end
        PH_E1: first_due  = 1'b1;
        PH_E2: second_due = 1'b1;
        PH_E3: begin
          if (is_pad) begin
            third_is_pad_next = 1'b1;
            sextet_three_next = '0;
            phase_next        = PH_E4;
          end else if (invalid) begin
            res[0]     = '{data: 8'd0, status: ST_ERROR, count: count_next};
            n_res      = 3'd1;
            phase_next = PH_IDLE;
          end else begin
            third_is_pad_next = 1'b0;
            sextet_three_next = s[5:0];
            phase_next        = PH_E4;
          end
        end
        PH_E4: begin
          if ((!is_pad && invalid) || (third_is_pad && !is_pad)) begin
            res[0]     = '{data: 8'd0, status: ST_ERROR, count: count_next};
            n_res      = 3'd1;
            phase_next = PH_IDLE;
          end else begin
            if (count_next != COUNT_MAX) count_next = count_next + 1'b1;
            res[0] = '{data: {sextet_one, sextet_two[5:4]}, status: ST_DATA,
                       count: count_next};
            n_res  = 3'd1;
            if (!third_is_pad) begin
              if (count_next != COUNT_MAX) count_next = count_next + 1'b1;
              res[1] = '{data: {sextet_two[3:0], sextet_three[5:2]}, status: ST_DATA,
                         count: count_next};
              n_res  = 3'd2;
              if (!is_pad) begin
                if (count_next != COUNT_MAX) count_next = count_next + 1'b1;
                res[2] = '{data: {sextet_three[1:0], s[5:0]}, status: ST_DATA,
                           count: count_next};
                n_res  = 3'd3;
              end
            end
            if (is_pad) begin
              res[n_res[1:0]] = '{data: 8'd0, status: ST_DONE, count: count_next};
              n_res           = n_res + 3'd1;
              phase_next      = PH_IDLE;
            end else begin
              phase_next = PH_E1;
            end
            third_is_pad_next = 1'b0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    // First character of a group, or a carriage return that closes the line.
    if (first_due) begin
      if (c == CH_CR) begin
        res[0]     = '{data: 8'd0, status: ST_DONE, count: count_next};
        n_res      = 3'd1;
        phase_next = PH_IDLE;
      end else if (invalid) begin
        res[0]     = '{data: 8'd0, status: ST_ERROR, count: count_next};
        n_res      = 3'd1;
        phase_next = PH_IDLE;
      end else begin
        sextet_one_next = s[5:0];
        phase_next      = PH_E2;
      end
    end

    if (second_due) begin
      if (invalid) begin
        res[0]     = '{data: 8'd0, status: ST_ERROR, count: count_next};
        n_res      = 3'd1;
        phase_next = PH_IDLE;
      end else begin
        sextet_one_next = s_one;
        sextet_two_next = s[5:0];
        phase_next      = PH_E3;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      sextet_one    <= '0;
      sextet_two    <= '0;
      sextet_three  <= '0;
      third_is_pad  <= 1'b0;
      decoded_count <= '0;
    end else if (take) begin
      phase         <= phase_next;
      sextet_one    <= sextet_one_next;
      sextet_two    <= sextet_two_next;
      sextet_three  <= sextet_three_next;
      third_is_pad  <= third_is_pad_next;
      decoded_count <= count_next;
    end
  end

  // Result buffer control. A taken character replaces the buffer, which at that
  // point is either empty or handing out its final beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      rd_idx    <= '0;
      last_idx  <= '0;
    end else if (take) begin
      if (n_res != 3'd0) begin
        buf_valid <= 1'b1;
        rd_idx    <= '0;
        last_idx  <= 2'(n_res - 3'd1);
      end else begin
        buf_valid <= 1'b0;
      end
    end else if (pop) begin
      if (pop_last) begin
        buf_valid <= 1'b0;
      end else begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  // Result payload needs no reset; it is only read while buf_valid is set.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        entries[i] <= res[i];
      end
    end
  end

  // Output port: the count is shown in 16 bits, truncated or zero-extended.
  logic [COUNT_WIDTH+15:0] count_wide;

  assign count_wide         = {16'd0, entries[rd_idx].count};
  assign results.valid      = buf_valid;
  assign results.out_byte   = entries[rd_idx].data;
  assign results.status     = entries[rd_idx].status;
  assign results.byte_count = count_wide[15:0];
  assign results.last       = (rd_idx == last_idx);

endmodule

FILE: tb/tb_base64_decoder.sv
// Self-checking testbench of the base64 line decoder: random and directed lines.
`timescale 1ns / 1ps

module tb_base64_decoder;
  import b64d_pkg::*;

  // The timeout allows for the slowest legal run: every character waiting out the longest
  // sender gap and every result the longest receiver stall, taken several times over.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_REPORTS = 30;
  localparam int RANDOM_ITEMS = 190;
  localparam int DRAIN_CYCLES = 20;

  // One character beat as the sender queues it.
  typedef struct packed {
    logic [7:0] ch;
    logic       start;
  } char_beat_t;

  // One decoder result as it is expected on the output channel.
  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] count;
    logic        last;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b64d_char_if   chars_if ();
  b64d_result_if results_if ();

  base64_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always #2 clk = ~clk;

  char_beat_t  pending_chars[$];
  dec_result_t awaited_results[$];
  dec_result_t step_results[$];

  int unsigned cycle_count = 0;
  int          fail_count = 0;
  int          chars_total = 0;
  int          chars_taken = 0;
  int          char_gap = 0;
  int          take_gap = 0;
  int          send_wait;
  int          recv_wait;

  // Shadow copy of the line parser. It starts in its reset state, and reset is applied once.
  logic [2:0] ln_phase = PH_IDLE;
  logic [5:0] grp_s1 = '0;
  logic [5:0] grp_s2 = '0;
  logic [5:0] grp_s3 = '0;
  logic       grp_pad3 = 1'b0;
  count_t     ln_count = '0;

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Maps a character to its 6-bit value. Bit 6 set means it is not in the alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
    if (c == CH_PLUS) return {1'b0, SEXTET_PLUS};
    if (c == CH_SLASH) return 7'd63;
    return 7'h40;
  endfunction

  // Records one result of the current character. Data bytes bump the saturating line count.
  function automatic void post_result(input logic [7:0] data, input logic [1:0] status);
    dec_result_t r;
    if (status == ST_DATA && ln_count != '1) ln_count = ln_count + 1'b1;
    r.data   = (status == ST_DATA) ? data : 8'h00;
    r.status = status;
    r.count  = 16'(ln_count);
    r.last   = 1'b0;
    step_results.push_back(r);
  endfunction

  // First character of a group. A carriage return here closes the line cleanly.
  function automatic void open_group(input logic [7:0] c, input logic [6:0] v);
    if (c == CH_CR) begin
      post_result(8'h00, ST_DONE);
      ln_phase = PH_IDLE;
    end else if (v[6]) begin
      post_result(8'h00, ST_ERROR);
      ln_phase = PH_IDLE;
    end else begin
      grp_s1 = v[5:0];
      ln_phase = PH_E2;
    end
  endfunction

  function automatic void take_second(input logic [6:0] v);
    if (v[6]) begin
      post_result(8'h00, ST_ERROR);
      ln_phase = PH_IDLE;
    end else begin
      grp_s2 = v[5:0];
      ln_phase = PH_E3;
    end
  endfunction

  // Fourth character: emits the group's bytes, or an error on bad padding.
  function automatic void close_group(input logic [7:0] c, input logic [6:0] v);
    if ((c != CH_PAD && v[6]) || (grp_pad3 && c != CH_PAD)) begin
      post_result(8'h00, ST_ERROR);
      ln_phase = PH_IDLE;
    end else begin
      post_result({grp_s1, grp_s2[5:4]}, ST_DATA);
      if (!grp_pad3) begin
        post_result({grp_s2[3:0], grp_s3[5:2]}, ST_DATA);
        if (c != CH_PAD) post_result({grp_s3[1:0], v[5:0]}, ST_DATA);
      end
      if (c == CH_PAD) begin
        post_result(8'h00, ST_DONE);
        ln_phase = PH_IDLE;
      end else begin
        ln_phase = PH_E1;
      end
      grp_pad3 = 1'b0;
    end
  endfunction

  // Advances the shadow parser by one accepted character and queues what it should produce.
  function automatic void decode_char(input logic [7:0] c, input logic start);
    logic [6:0]  v;
    dec_result_t r;
    v = sextet_value(c);
    step_results.delete();
    if (start) begin
      // A line start abandons whatever line was open, silently.
      ln_count = '0;
      grp_pad3 = 1'b0;
      if (c == CH_PLUS) ln_phase = PH_PLUS;
      else open_group(c, v);
    end else begin
      case (ln_phase)
        PH_PLUS: begin
          // A leading plus that is not followed by a space was really alphabet value 62.
          if (c == CH_SPACE) begin
            ln_phase = PH_E1;
          end else begin
            grp_s1 = SEXTET_PLUS;
            take_second(v);
          end
        end
        PH_E1: open_group(c, v);
        PH_E2: take_second(v);
        PH_E3: begin
          if (c == CH_PAD) begin
            grp_pad3 = 1'b1;
            grp_s3 = '0;
            ln_phase = PH_E4;
          end else if (v[6]) begin
            post_result(8'h00, ST_ERROR);
            ln_phase = PH_IDLE;
          end else begin
            grp_pad3 = 1'b0;
            grp_s3 = v[5:0];
            ln_phase = PH_E4;
          end
        end
        PH_E4: close_group(c, v);
        default: ln_phase = PH_IDLE;
      endcase
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  function automatic char_beat_t beat(input logic [7:0] c, input logic start);
    char_beat_t b;
    b.ch = c;
    b.start = start;
    return b;
  endfunction

  function automatic void add_char(input logic [7:0] c, input logic start);
    pending_chars.push_back(beat(c, start));
    chars_total++;
  endfunction

  function automatic logic [7:0] alphabet_char(input int unsigned k);
    if (k < 26) return 8'(k) + "A";
    if (k < 52) return 8'(k - 26) + "a";
    if (k < 62) return 8'(k - 52) + "0";
    if (k == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  // Mostly well-formed lines with random content; some are cut short or corrupted so that
  // every error path and the mid-line restart are reached as well.
  task automatic queue_random_lines(input int target);
    char_beat_t  line_q[$];
    char_beat_t  b;
    logic        first;
    logic [7:0]  c;
    int          groups;
    int          ending;
    int          pos;
    int          made;
    made = 0;
    while (made < target) begin
      line_q.delete();
      first = 1'b1;
      // Stray bytes between lines; ignored unless the previous line is still open.
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(beat(8'($urandom_range(0, 255)), 1'b0));
      end
      if ($urandom_range(0, 3) == 0) begin
        line_q.push_back(beat(CH_PLUS, 1'b1));
        line_q.push_back(beat(CH_SPACE, 1'b0));
        first = 1'b0;
      end
      groups = $urandom_range(0, 4);
      for (int g = 0; g < groups * 4; g++) begin
        c = alphabet_char($urandom_range(0, 63));
        if (first && $urandom_range(0, 5) == 0) c = CH_PLUS;
        line_q.push_back(beat(c, first));
        first = 1'b0;
      end
      ending = $urandom_range(0, 9);
      if (ending < 4) begin
        line_q.push_back(beat(CH_CR, first));
      end else if (ending < 8) begin
        // One pad keeps three data characters, two pads keep two.
        for (int i = 0; i < 4; i++) begin
          if (i < ((ending < 6) ? 3 : 2)) c = alphabet_char($urandom_range(0, 63));
          else c = CH_PAD;
          line_q.push_back(beat(c, first));
          first = 1'b0;
        end
      end
      if (line_q.size() > 0 && $urandom_range(0, 9) < 3) begin
        pos = $urandom_range(0, line_q.size() - 1);
        b = line_q[pos];
        case ($urandom_range(0, 2))
          0: b.ch = 8'($urandom_range(0, 255));
          1: begin
            case ($urandom_range(0, 3))
              0: b.ch = CH_PAD;
              1: b.ch = CH_CR;
              2: b.ch = CH_PLUS;
              default: b.ch = CH_SPACE;
            endcase
          end
          default: b.start = 1'b1;
        endcase
        line_q[pos] = b;
      end
      foreach (line_q[i]) add_char(line_q[i].ch, line_q[i].start);
      made += line_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Handshake timing
  // ---------------------------------------------------------------------------------------

  // Each side draws a random wait per beat, except for one quarter of the run's cycles,
  // where neither side idles so that back-to-back traffic is exercised too.
  function automatic int draw_wait();
    if ((cycle_count % 1024) >= 768) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Character driver. The valid is held while the decoder stalls; after each accepted
  // beat the model is advanced and a fresh gap is drawn before the next character.
  always @(posedge clk) begin
    char_beat_t nxt;
    if (rst) begin
      chars_if.valid <= 1'b0;
      char_gap <= 0;
    end else if (!(chars_if.valid && !chars_if.ready)) begin
      send_wait = char_gap;
      if (chars_if.valid) begin
        decode_char(chars_if.in_char, chars_if.line_start);
        chars_taken++;
        send_wait = draw_wait();
      end
      if (send_wait == 0 && pending_chars.size() > 0) begin
        nxt = pending_chars.pop_front();
        chars_if.in_char <= nxt.ch;
        chars_if.line_start <= nxt.start;
        chars_if.valid <= 1'b1;
        char_gap <= 0;
      end else begin
        chars_if.valid <= 1'b0;
        char_gap <= (send_wait > 0) ? send_wait - 1 : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  function automatic void flag_field(input string field, input logic [15:0] want,
                                     input logic [15:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Compares one accepted result beat with the oldest expectation, field by field.
  function automatic void check_result();
    dec_result_t want;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: result beat with none expected, expected nothing, actual %0h/%0h/%0h/%0b",
                 $time, results_if.out_byte, results_if.status, results_if.byte_count,
                 results_if.last);
      end
    end else begin
      want = awaited_results.pop_front();
      if (results_if.out_byte !== want.data) flag_field("out_byte", 16'(want.data),
                                                         16'(results_if.out_byte));
      if (results_if.status !== want.status) flag_field("status", 16'(want.status),
                                                         16'(results_if.status));
      if (results_if.byte_count !== want.count) flag_field("byte_count", want.count,
                                                            results_if.byte_count);
      if (results_if.last !== want.last) flag_field("last", 16'(want.last),
                                                     16'(results_if.last));
    end
  endfunction

  // Result monitor. The ready stays high over idle cycles and drops for the drawn stall
  // after each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      take_gap <= 0;
    end else begin
      recv_wait = take_gap;
      if (results_if.valid && results_if.ready) begin
        check_result();
        recv_wait = draw_wait();
      end
      if (recv_wait == 0) begin
        results_if.ready <= 1'b1;
        take_gap <= 0;
      end else begin
        results_if.ready <= 1'b0;
        take_gap <= recv_wait - 1;
      end
    end
  end

  // Watchdog: a hung decoder ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    chars_if.valid = 1'b0;
    chars_if.in_char = 8'h00;
    chars_if.line_start = 1'b0;
    results_if.ready = 1'b0;

    // A character with no line open produces nothing.
    add_char("Q", 1'b0);
    // An empty line: carriage return as the first character.
    add_char(CH_CR, 1'b1);
    // The "+ " prefix, a group of the top alphabet values, then a clean end.
    add_char(CH_PLUS, 1'b1);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_SLASH, 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char("z", 1'b0);
    add_char("9", 1'b0);
    add_char(CH_CR, 1'b0);
    // A plus with no space after it opens the first group; two pads leave one byte.
    add_char(CH_PLUS, 1'b1);
    add_char("A", 1'b0);
    add_char(CH_PAD, 1'b0);
    add_char(CH_PAD, 1'b0);
    // One pad leaves two bytes.
    add_char("a", 1'b1);
    add_char("0", 1'b0);
    add_char("C", 1'b0);
    add_char(CH_PAD, 1'b0);
    // Pad in the first place, then in the second place.
    add_char(CH_PAD, 1'b1);
    add_char("A", 1'b1);
    add_char(CH_PAD, 1'b0);
    // Pad in the third place followed by a data character is malformed.
    add_char("A", 1'b1);
    add_char("A", 1'b0);
    add_char(CH_PAD, 1'b0);
    add_char("B", 1'b0);
    // A new line start in the middle of a group, on a byte above 127.
    add_char("A", 1'b1);
    add_char(8'hff, 1'b1);
    // A carriage return inside a group is an error; the null byte after it is ignored.
    add_char("A", 1'b1);
    add_char("B", 1'b0);
    add_char(CH_CR, 1'b0);
    add_char(8'h00, 1'b0);

    queue_random_lines(RANDOM_ITEMS);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every character to be taken, then for every expected result to arrive,
    // then a little longer so that any spurious extra beat is caught.
    while (chars_taken < chars_total) @(posedge clk);
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/b64d_pkg.sv
design/b64d_char_if.sv
design/b64d_result_if.sv
design/base64_decoder.sv
tb/tb_base64_decoder.sv
